[src/sbcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block cache directory package
// Shared widths, payload structs, codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package sbcd_pkg;

   localparam int NUM_BLOCKS        = 32;
   localparam int NUM_SETS          = 8;
   localparam int SECTORS_PER_BLOCK = 8;

   localparam int SLOT_W = $clog2(NUM_BLOCKS);
   localparam int SET_W  = $clog2(NUM_SETS);
   localparam int OFF_W  = $clog2(SECTORS_PER_BLOCK);
   localparam int TAG_W  = 32 - SET_W - OFF_W;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int RANK_W = CNT_W;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_PUT   = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_DONE  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_code_type;

   typedef enum logic [2:0] {
      STAT_HIT      = 3'd0,
      STAT_FILLED   = 3'd1,
      STAT_RANGE    = 3'd2,
      STAT_PUT_MISS = 3'd3,
      STAT_DONE     = 3'd4
   } status_code_type;

   typedef enum logic [1:0] {
      CSR_WRITE_THROUGH = 2'd0,
      CSR_READ_LIMIT    = 2'd1,
      CSR_PUT_LIMIT     = 2'd2,
      CSR_PROTECTED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] sector_num;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [2:0]  status;
      logic [31:0] disk_sector;
      logic [4:0]  slot;
      logic [2:0]  sector_offset;
      logic        last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_LOOKUP, ST_READ_HIT, ST_PUT_HIT, ST_PUT_DONE,
      ST_BEST, ST_VICTIM, ST_PROT, ST_FILL, ST_FILLED, ST_FLUSH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_LOOKUP, OP_FRONT, OP_FRONT_DIRTY, OP_ALLOC,
      OP_BEST, OP_LRU, OP_UNLINK, OP_LINK, OP_FLUSH_INIT, OP_FLUSH_STEP
   } op_type;

   typedef enum logic [3:0] {
      EMIT_NONE, EMIT_RANGE, EMIT_PUT_MISS, EMIT_DONE, EMIT_HIT, EMIT_WRITE_CUR,
      EMIT_WRITE_REQ, EMIT_READ, EMIT_FILLED, EMIT_FLUSH_WR
   } emit_type;

   typedef struct packed {
      op_type   op;
      emit_type emit;
   } dp_cmd_type;

   typedef struct packed {
      req_code_type req_kind;
      logic         write_through;
      logic         read_oor;
      logic         put_oor;
      logic         hit;
      logic         free_nz;
      logic         lru_found;
      logic         is_prot;
      logic         cur_dirty;
      logic         fl_in_range;
      logic         fl_dirty;
      logic         fl_last_set;
   } dp_status_type;

endpackage

[src/sbcd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block cache directory datapath
// Slot tables, set counts, config registers and response register.
// ----------------------------------------------------------------------------
module sbcd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sbcd_pkg::req_item_type  req_item,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  sbcd_pkg::dp_cmd_type    cmd,
   output sbcd_pkg::dp_status_type sts,
   output logic                 rsp_strobe,
   output sbcd_pkg::rsp_item_type  rsp_item
);
   import sbcd_pkg::*;

   logic               wt_ff;
   logic [31:0]        read_limit_ff, put_limit_ff, prot_ff;

   req_item_type       req_ff;
   logic [TAG_W-1:0]   tag_ff [NUM_BLOCKS], tag_in [NUM_BLOCKS];
   logic [SET_W-1:0]   set_ff [NUM_BLOCKS], set_in [NUM_BLOCKS];
   logic [SLOT_W-1:0]  rec_ff [NUM_BLOCKS], rec_in [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] dirty_ff, dirty_in, used_ff, used_in;
   logic [CNT_W-1:0]   cnt_ff [NUM_SETS], cnt_in [NUM_SETS];
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [SLOT_W-1:0]  s_ff, s_in;
   logic [SET_W-1:0]   best_ff, best_in, fset_ff, fset_in;
   logic [RANK_W-1:0]  frank_ff, frank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic [OFF_W-1:0]   r_off;
   logic [SET_W-1:0]   r_set;
   logic [TAG_W-1:0]   r_tag;
   logic [31:0]        r_aligned, cur_sector, fl_sector;
   logic               hit_any, lru_any, fl_any;
   logic [SLOT_W-1:0]  hit_idx, lru_idx, fl_idx;
   logic [SET_W-1:0]   best_c;

   assign r_off     = req_ff.sector_num[OFF_W-1:0];
   assign r_set     = req_ff.sector_num[OFF_W +: SET_W];
   assign r_tag     = req_ff.sector_num[31 -: TAG_W];
   assign r_aligned = {req_ff.sector_num[31:OFF_W], {OFF_W{1'b0}}};
   assign cur_sector = {tag_ff[s_ff], set_ff[s_ff], {OFF_W{1'b0}}};
   assign fl_sector  = {tag_ff[fl_idx], set_ff[fl_idx], {OFF_W{1'b0}}};

   // parallel searches, lowest slot wins
   always_comb begin
      hit_any = 1'b0; hit_idx = '0;
      lru_any = 1'b0; lru_idx = '0;
      fl_any  = 1'b0; fl_idx  = '0;
      for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
         if (used_ff[i] && set_ff[i] == r_set && tag_ff[i] == r_tag) begin
            hit_any = 1'b1; hit_idx = SLOT_W'(i);
         end
         if (used_ff[i] && set_ff[i] == best_ff &&
             {1'b0, rec_ff[i]} == cnt_ff[best_ff] - CNT_W'(1)) begin
            lru_any = 1'b1; lru_idx = SLOT_W'(i);
         end
         if (used_ff[i] && set_ff[i] == fset_ff && {1'b0, rec_ff[i]} == frank_ff) begin
            fl_any = 1'b1; fl_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      best_c = '0;
      for (int i = 1; i < NUM_SETS; i++)
         if (cnt_ff[i] > cnt_ff[best_c]) best_c = SET_W'(i);
   end

   always_comb begin
      sts.req_kind      = req_code_type'(req_ff.req_type);
      sts.write_through = wt_ff;
      sts.read_oor      = req_ff.sector_num >= read_limit_ff;
      sts.put_oor       = req_ff.sector_num >= put_limit_ff;
      sts.hit           = hit_any;
      sts.free_nz       = free_ff != '0;
      sts.lru_found     = lru_any;
      sts.is_prot       = cur_sector == {prot_ff[31:OFF_W], {OFF_W{1'b0}}};
      sts.cur_dirty     = dirty_ff[s_ff];
      sts.fl_in_range   = frank_ff < cnt_ff[fset_ff];
      sts.fl_dirty      = fl_any && dirty_ff[fl_idx];
      sts.fl_last_set   = fset_ff == SET_W'(NUM_SETS - 1);
   end

   always_comb begin
      tag_in = tag_ff; set_in = set_ff; rec_in = rec_ff;
      dirty_in = dirty_ff; used_in = used_ff; cnt_in = cnt_ff; free_in = free_ff;
      s_in = s_ff; best_in = best_ff; fset_in = fset_ff; frank_in = frank_ff;
      case (cmd.op)
         OP_LOOKUP: s_in = hit_idx;
         OP_FRONT, OP_FRONT_DIRTY: begin
            for (int i = 0; i < NUM_BLOCKS; i++)
               if (SLOT_W'(i) != s_ff && used_ff[i] && set_ff[i] == set_ff[s_ff] &&
                   rec_ff[i] < rec_ff[s_ff])
                  rec_in[i] = rec_ff[i] + SLOT_W'(1);
            rec_in[s_ff] = '0;
            if (cmd.op == OP_FRONT_DIRTY) dirty_in[s_ff] = !wt_ff;
         end
         OP_ALLOC: begin
            free_in = free_ff - CNT_W'(1);
            s_in = SLOT_W'(free_ff - CNT_W'(1));
            dirty_in[SLOT_W'(free_ff - CNT_W'(1))] = 1'b0;
         end
         OP_BEST: best_in = best_c;
         OP_LRU:  s_in = lru_idx;
         OP_UNLINK: begin
            for (int i = 0; i < NUM_BLOCKS; i++)
               if (SLOT_W'(i) != s_ff && used_ff[i] && set_ff[i] == set_ff[s_ff] &&
                   rec_ff[i] > rec_ff[s_ff])
                  rec_in[i] = rec_ff[i] - SLOT_W'(1);
            if (cnt_ff[set_ff[s_ff]] != '0)
               cnt_in[set_ff[s_ff]] = cnt_ff[set_ff[s_ff]] - CNT_W'(1);
            used_in[s_ff]  = 1'b0;
            dirty_in[s_ff] = 1'b0;
         end
         OP_LINK: begin
            for (int i = 0; i < NUM_BLOCKS; i++)
               if (used_ff[i] && set_ff[i] == r_set) rec_in[i] = rec_ff[i] + SLOT_W'(1);
            set_in[s_ff]  = r_set;
            tag_in[s_ff]  = r_tag;
            rec_in[s_ff]  = '0;
            used_in[s_ff] = 1'b1;
            cnt_in[r_set] = cnt_ff[r_set] + CNT_W'(1);
         end
         OP_FLUSH_INIT: begin
            fset_in = '0; frank_in = '0;
         end
         OP_FLUSH_STEP: begin
            if (frank_ff < cnt_ff[fset_ff]) begin
               frank_in = frank_ff + RANK_W'(1);
               if (fl_any) dirty_in[fl_idx] = 1'b0;
            end else begin
               frank_in = '0;
               fset_in  = fset_ff + SET_W'(1);
            end
         end
         default: ;
      endcase
   end

   // build the response for this cycle's emit code
   always_comb begin
      rsp_in = '0;
      rsp_valid_in = cmd.emit != EMIT_NONE;
      case (cmd.emit)
         EMIT_RANGE:    begin rsp_in.status = STAT_RANGE;    rsp_in.last = 1'b1; end
         EMIT_PUT_MISS: begin rsp_in.status = STAT_PUT_MISS; rsp_in.last = 1'b1; end
         EMIT_DONE:     begin rsp_in.status = STAT_DONE;     rsp_in.last = 1'b1; end
         EMIT_HIT, EMIT_FILLED: begin
            rsp_in.status = (cmd.emit == EMIT_HIT) ? STAT_HIT : STAT_FILLED;
            rsp_in.disk_sector = r_aligned;
            rsp_in.slot = s_ff;
            rsp_in.sector_offset = r_off;
            rsp_in.last = 1'b1;
         end
         EMIT_WRITE_CUR: begin
            rsp_in.item_kind = KIND_WRITE; rsp_in.disk_sector = cur_sector;
            rsp_in.slot = s_ff;
         end
         EMIT_WRITE_REQ: begin
            rsp_in.item_kind = KIND_WRITE; rsp_in.disk_sector = r_aligned;
            rsp_in.slot = s_ff;
         end
         EMIT_READ: begin
            rsp_in.item_kind = KIND_READ; rsp_in.disk_sector = r_aligned;
            rsp_in.slot = s_ff;
         end
         EMIT_FLUSH_WR: begin
            rsp_in.item_kind = KIND_WRITE; rsp_in.disk_sector = fl_sector;
            rsp_in.slot = fl_idx;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in; set_ff <= set_in; rec_ff <= rec_in;
      s_ff <= s_in; best_ff <= best_in; fset_ff <= fset_in; frank_ff <= frank_in;
      rsp_ff <= rsp_in;
      if (cmd.op == OP_LOAD) req_ff <= req_item;
      if (reset) begin
         dirty_ff <= '0; used_ff <= '0; free_ff <= CNT_W'(NUM_BLOCKS);
         for (int i = 0; i < NUM_SETS; i++) cnt_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         wt_ff <= 1'b0; read_limit_ff <= '1; put_limit_ff <= '1; prot_ff <= '0;
      end else begin
         dirty_ff <= dirty_in; used_ff <= used_in; free_ff <= free_in; cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_WRITE_THROUGH: wt_ff <= csr_data[0];
               CSR_READ_LIMIT:    read_limit_ff <= csr_data;
               CSR_PUT_LIMIT:     put_limit_ff <= csr_data;
               CSR_PROTECTED:     prot_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

[src/sbcd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block cache directory controller
// Sequences lookup, eviction, fill and flush steps on the datapath.
// ----------------------------------------------------------------------------
module sbcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  sbcd_pkg::dp_status_type sts,
   output sbcd_pkg::dp_cmd_type    cmd
);
   import sbcd_pkg::*;

   state_type state_ff, state_in;
   logic      prot_done_ff, prot_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prot_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prot_done_ff <= prot_done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      prot_done_in = prot_done_ff;
      cmd.op = OP_NONE;
      cmd.emit = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            prot_done_in = 1'b0;
            if (start) begin
               cmd.op = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (sts.req_kind)
               REQ_READ: if (sts.read_oor) begin
                  cmd.emit = EMIT_RANGE; state_in = ST_IDLE;
               end else state_in = ST_LOOKUP;
               REQ_PUT: if (sts.put_oor) begin
                  cmd.emit = EMIT_RANGE; state_in = ST_IDLE;
               end else state_in = ST_LOOKUP;
               REQ_FLUSH: if (sts.write_through) begin
                  cmd.emit = EMIT_DONE; state_in = ST_IDLE;
               end else begin
                  cmd.op = OP_FLUSH_INIT; state_in = ST_FLUSH;
               end
               default: begin
                  cmd.emit = EMIT_DONE; state_in = ST_IDLE;
               end
            endcase
         end
         ST_LOOKUP: begin
            if (sts.hit) begin
               cmd.op = OP_LOOKUP;
               state_in = (sts.req_kind == REQ_PUT) ? ST_PUT_HIT : ST_READ_HIT;
            end else if (sts.req_kind == REQ_PUT) begin
               cmd.emit = EMIT_PUT_MISS; state_in = ST_IDLE;
            end else if (sts.free_nz) begin
               cmd.op = OP_ALLOC; state_in = ST_FILL;
            end else state_in = ST_BEST;
         end
         ST_READ_HIT: begin
            cmd.op = OP_FRONT; cmd.emit = EMIT_HIT; state_in = ST_IDLE;
         end
         ST_PUT_HIT: begin
            cmd.op = OP_FRONT_DIRTY;
            if (sts.write_through) cmd.emit = EMIT_WRITE_REQ;
            state_in = ST_PUT_DONE;
         end
         ST_PUT_DONE: begin
            cmd.emit = EMIT_HIT; state_in = ST_IDLE;
         end
         ST_BEST: begin
            cmd.op = OP_BEST; state_in = ST_VICTIM;
         end
         ST_VICTIM: begin
            if (sts.lru_found) begin
               cmd.op = OP_LRU; state_in = ST_PROT;
            end else begin
               cmd.emit = EMIT_RANGE; state_in = ST_IDLE;
            end
         end
         ST_PROT: begin
            if (sts.is_prot && !prot_done_ff) begin
               cmd.op = OP_FRONT; prot_done_in = 1'b1; state_in = ST_VICTIM;
            end else begin
               cmd.op = OP_UNLINK;
               if (sts.cur_dirty) cmd.emit = EMIT_WRITE_CUR;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.op = OP_LINK; cmd.emit = EMIT_READ; state_in = ST_FILLED;
         end
         ST_FILLED: begin
            cmd.emit = EMIT_FILLED; state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            cmd.op = OP_FLUSH_STEP;
            if (sts.fl_in_range) begin
               if (sts.fl_dirty) cmd.emit = EMIT_FLUSH_WR;
            end else if (sts.fl_last_set) begin
               cmd.emit = EMIT_DONE; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

[src/sector_block_cache_directory_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block cache directory
// Directory of a set-indexed, per-set LRU disk sector cache with write-back
// or write-through policy; disk transfers come out as response items.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request's last response has been issued. Responses appear at
// most one per cycle on rsp_item, qualified by rsp_strobe for exactly one
// cycle, and cannot be held off: capture them as they come. The final
// response of each request is the completion, with last set. A miss with
// no free slot evicts the least recently used block of the fullest set,
// skipping the protected block once; a write-back flush walks the sets in
// turn, stepping through every block in use. Configuration writes are
// always accepted (csr_ready is tied high) and are meant to be issued
// only while the block is idle.
// ----------------------------------------------------------------------------
module sector_block_cache_directory_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sbcd_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output sbcd_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);
   import sbcd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   // config registers live in the datapath; accept every write
   assign csr_ready = 1'b1;

   sbcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   sbcd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
